// ===== sv/tlt_pkg.sv =====
// ----------------------------------------------------------------------------
// tlt_pkg
// Shared types, character codes and keyword tables for the toy language
// tokenizer: lexer state, token record and the per-byte helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package tlt_pkg;

  localparam int TW = 13;                 // offset, length and line width
  localparam logic [TW-1:0] TOP13 = '1;   // saturation value
  localparam int KW_COUNT  = 9;
  localparam int KW_MAXLEN = 8;
  localparam int SYM_SINGLE = 8;          // symbols found on a single byte

  // lexer modes
  typedef enum logic [3:0] {
    MODE_IDLE  = 4'd0,
    MODE_INT   = 4'd1,
    MODE_IDENT = 4'd2,
    MODE_STR   = 4'd3,
    MODE_CMT   = 4'd4,
    MODE_HELD  = 4'd5
  } lex_mode_t;

  // token kinds
  localparam logic [2:0] KIND_STR   = 3'd0;
  localparam logic [2:0] KIND_INT   = 3'd1;
  localparam logic [2:0] KIND_SYM   = 3'd2;
  localparam logic [2:0] KIND_KW    = 3'd3;
  localparam logic [2:0] KIND_IDENT = 3'd4;
  localparam logic [2:0] KIND_ERR   = 3'd5;

  // symbol codes that are not found by table lookup
  localparam logic [3:0] SYM_ASSIGN = 4'd8;
  localparam logic [3:0] SYM_EQEQ   = 4'd9;
  localparam logic [3:0] SYM_NEQ    = 4'd10;

  // character codes
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // keyword text, padded with zeros
  localparam logic [7:0] KW_TAB [KW_COUNT][KW_MAXLEN] = '{
    '{"s", "e", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"c", "a", "l", "l", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"c", "a", "l", "l", "_", "s", "e", "t"},
    '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
    '{"c", "a", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"v", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"f", "u", "n", "c", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"_", "c", "m", "t", 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd4, 4'd8, 4'd6, 4'd5, 4'd4, 4'd3, 4'd4, 4'd4
  };

  // single-byte symbols, code is the index
  localparam logic [7:0] SYM_CHARS [SYM_SINGLE] = '{
    ";", "(", ")", "{", "}", ",", "+", "*"
  };

  typedef struct packed {
    lex_mode_t             mode;
    logic [7:0]            held;
    logic [TW-1:0]         tstart;
    logic [TW-1:0]         tlen;
    logic [TW-1:0]         tline;
    logic [TW-1:0]         lcount;
    logic [TW-1:0]         boff;
    logic [KW_COUNT-1:0]   kwc;
  } lex_state_t;

  localparam lex_state_t LEX_RESET = '{
    mode:   MODE_IDLE,
    held:   8'h00,
    tstart: '0,
    tlen:   '0,
    tline:  13'd1,
    lcount: 13'd1,
    boff:   '0,
    kwc:    '1
  };

  typedef struct packed {
    logic [2:0]    kind;
    logic [TW-1:0] start;
    logic [TW-1:0] len;
    logic [TW-1:0] line;
    logic [3:0]    sym;
    logic [3:0]    kw;
    logic          last;
  } tok_t;

  function automatic logic [TW-1:0] sat_inc(input logic [TW-1:0] v);
    return (v != TOP13) ? v + 13'd1 : TOP13;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_ident(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || is_digit(c) || (c == CH_UNDER);
  endfunction

  function automatic tok_t mk_tok(input logic [2:0] kind, input logic [TW-1:0] start,
                                  input logic [TW-1:0] len, input logic [TW-1:0] line,
                                  input logic [3:0] sym, input logic [3:0] kw);
    tok_t t;
    t.kind  = kind;
    t.start = start;
    t.len   = len;
    t.line  = line;
    t.sym   = sym;
    t.kw    = kw;
    t.last  = 1'b0;
    return t;
  endfunction

  // drop keywords that do not have byte c at position pos
  function automatic logic [KW_COUNT-1:0] kw_filter(input logic [KW_COUNT-1:0] mask,
                                                    input logic [TW-1:0] pos,
                                                    input logic [7:0] c);
    logic [KW_COUNT-1:0] m;
    m = mask;
    for (int i = 0; i < KW_COUNT; i++) begin
      if ((pos >= TW'(KW_LEN[i])) || (KW_TAB[i][pos[2:0]] != c)) begin
        m[i] = 1'b0;
      end
    end
    return m;
  endfunction

  // identifier or keyword token, first matching keyword wins
  function automatic tok_t finish_ident(input logic [KW_COUNT-1:0] cand,
                                        input logic [TW-1:0] len,
                                        input logic [TW-1:0] start,
                                        input logic [TW-1:0] line);
    tok_t t;
    logic found;
    t = mk_tok(KIND_IDENT, start, len, line, 4'd0, 4'd0);
    found = 1'b0;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (!found && cand[i] && (len == TW'(KW_LEN[i]))) begin
        found  = 1'b1;
        t.kind = KIND_KW;
        t.kw   = 4'(i);
      end
    end
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== sv/tlt_step.sv =====
// ----------------------------------------------------------------------------
// tlt_step
// Per-byte lexer step: from the current lexer state and one source byte,
// forms the next state and up to two tokens, in emission order.
// ----------------------------------------------------------------------------
`default_nettype none

module tlt_step
  import tlt_pkg::*;
(
  input  lex_state_t st,
  input  logic [7:0] in_byte,
  input  logic       end_of_text,
  output lex_state_t st_next,
  output tok_t       res0,
  output tok_t       res1,
  output logic [1:0] res_count
);

  lex_state_t s1;
  tok_t       e0, e1, e2;
  logic       e0v, e1v, e2v;
  logic       do_start, do_ident;
  logic [KW_COUNT-1:0] id_mask;
  logic       sym_hit;
  logic [3:0] sym_idx;

  // single-byte symbol lookup
  always_comb begin
    sym_hit = 1'b0;
    sym_idx = 4'd0;
    for (int i = 0; i < SYM_SINGLE; i++) begin
      if (!sym_hit && (in_byte == SYM_CHARS[i])) begin
        sym_hit = 1'b1;
        sym_idx = 4'(i);
      end
    end
  end

  // mode dispatch, identifier continuation and token start
  always_comb begin
    s1       = st;
    e0v      = 1'b0;
    e0       = mk_tok(KIND_STR, '0, '0, '0, 4'd0, 4'd0);
    e1v      = 1'b0;
    e1       = mk_tok(KIND_SYM, st.boff, 13'd1, st.lcount, sym_idx, 4'd0);
    do_start = 1'b0;
    do_ident = 1'b0;
    id_mask  = st.kwc;

    unique case (st.mode)
      MODE_INT: begin
        if (is_digit(in_byte)) begin
          s1.tlen = sat_inc(st.tlen);
        end else begin
          e0v      = 1'b1;
          e0       = mk_tok(KIND_INT, st.tstart, st.tlen, st.tline, 4'd0, 4'd0);
          do_start = 1'b1;
        end
      end
      MODE_IDENT: begin
        do_ident = 1'b1;
      end
      MODE_STR: begin
        if (in_byte == CH_QUOTE) begin
          if (st.tlen == '0) begin
            // empty string: opening quote becomes a one-byte identifier
            e0v       = 1'b1;
            e0        = mk_tok(KIND_IDENT, st.tstart - 13'd1, 13'd1, st.tline, 4'd0, 4'd0);
            s1.tstart = st.boff + 13'd1;
            s1.tline  = st.lcount;
          end else begin
            e0v     = 1'b1;
            e0      = mk_tok(KIND_STR, st.tstart, st.tlen, st.tline, 4'd0, 4'd0);
            s1.mode = MODE_IDLE;
          end
        end else begin
          s1.tlen = sat_inc(st.tlen);
        end
      end
      MODE_CMT: begin
        if (in_byte == CH_NL) begin
          s1.lcount = sat_inc(st.lcount);
          s1.mode   = MODE_IDLE;
        end
      end
      MODE_HELD: begin
        priority if (st.held == CH_EQ) begin
          e0v = 1'b1;
          if (in_byte == CH_EQ) begin
            e0      = mk_tok(KIND_SYM, st.tstart, 13'd2, st.tline, SYM_EQEQ, 4'd0);
            s1.mode = MODE_IDLE;
          end else begin
            e0       = mk_tok(KIND_SYM, st.tstart, 13'd1, st.tline, SYM_ASSIGN, 4'd0);
            do_start = 1'b1;
          end
        end else if ((st.held == CH_BANG) && (in_byte == CH_EQ)) begin
          e0v     = 1'b1;
          e0      = mk_tok(KIND_SYM, st.tstart, 13'd2, st.tline, SYM_NEQ, 4'd0);
          s1.mode = MODE_IDLE;
        end else if ((st.held == CH_SLASH) && (in_byte == CH_SLASH)) begin
          s1.mode = MODE_CMT;
        end else begin
          // lone '!' or '/' opens an identifier that is never a keyword
          s1.mode  = MODE_IDENT;
          id_mask  = '0;
          do_ident = 1'b1;
        end
      end
      default: begin
        do_start = 1'b1;
      end
    endcase

    // identifier continues or ends
    if (do_ident) begin
      if (is_ident(in_byte)) begin
        s1.kwc  = kw_filter(id_mask, st.tlen, in_byte);
        s1.tlen = sat_inc(st.tlen);
      end else begin
        s1.kwc   = id_mask;
        e0v      = 1'b1;
        e0       = finish_ident(id_mask, st.tlen, st.tstart, st.tline);
        do_start = 1'b1;
      end
    end

    // first byte of a new token
    if (do_start) begin
      s1.mode = MODE_IDLE;
      priority if (in_byte == CH_NL) begin
        s1.lcount = sat_inc(st.lcount);
      end else if (in_byte == CH_SP) begin
        s1.mode = MODE_IDLE;
      end else if (in_byte == CH_QUOTE) begin
        s1.mode   = MODE_STR;
        s1.tstart = st.boff + 13'd1;
        s1.tlen   = '0;
        s1.tline  = st.lcount;
      end else if ((in_byte == CH_MINUS) || is_digit(in_byte)) begin
        s1.mode   = MODE_INT;
        s1.tstart = st.boff;
        s1.tlen   = 13'd1;
        s1.tline  = st.lcount;
      end else if ((in_byte == CH_EQ) || (in_byte == CH_BANG) || (in_byte == CH_SLASH)) begin
        s1.mode   = MODE_HELD;
        s1.held   = in_byte;
        s1.tstart = st.boff;
        s1.tlen   = 13'd1;
        s1.tline  = st.lcount;
      end else if (sym_hit) begin
        e1v = 1'b1;
      end else begin
        s1.mode   = MODE_IDENT;
        s1.tstart = st.boff;
        s1.tlen   = 13'd1;
        s1.tline  = st.lcount;
        s1.kwc    = kw_filter('1, '0, in_byte);
      end
    end
  end

  // end-of-text flush and offset advance
  always_comb begin
    e2v     = 1'b0;
    e2      = mk_tok(KIND_INT, s1.tstart, s1.tlen, s1.tline, 4'd0, 4'd0);
    st_next = s1;
    st_next.boff = st.boff + 13'd1;
    if (end_of_text) begin
      unique case (s1.mode)
        MODE_INT: begin
          e2v = 1'b1;
        end
        MODE_IDENT: begin
          e2v = 1'b1;
          e2  = finish_ident(s1.kwc, s1.tlen, s1.tstart, s1.tline);
        end
        MODE_HELD: begin
          e2v = 1'b1;
          if (s1.held == CH_EQ) begin
            e2 = mk_tok(KIND_SYM, s1.tstart, 13'd1, s1.tline, SYM_ASSIGN, 4'd0);
          end else begin
            e2 = mk_tok(KIND_IDENT, s1.tstart, 13'd1, s1.tline, 4'd0, 4'd0);
          end
        end
        MODE_STR: begin
          e2v = 1'b1;
          e2  = mk_tok(KIND_ERR, s1.tstart, s1.tlen, s1.tline, 4'd0, 4'd0);
        end
        default: begin
          e2v = 1'b0;
        end
      endcase
      st_next = LEX_RESET;
    end
  end

  // pack the valid tokens into two slots and mark the last one
  always_comb begin
    res0 = e2;
    res1 = e2;
    priority if (e0v) begin
      res0      = e0;
      res1      = e1v ? e1 : e2;
      res_count = (e1v || e2v) ? 2'd2 : 2'd1;
    end else if (e1v) begin
      res0      = e1;
      res_count = e2v ? 2'd2 : 2'd1;
    end else begin
      res_count = e2v ? 2'd1 : 2'd0;
    end
    res0.last = (res_count == 2'd1);
    res1.last = 1'b1;
  end

endmodule

`default_nettype wire

// ===== sv/toy_language_tokenizer.sv =====
// Tokens enter the registered token queue at their byte transfer, in order.
// Throughput: one byte per cycle while the master side is ready and bytes
// average at most one token each; a byte's second token is absorbed by the
// four-entry token queue (input ready while the queue holds two or fewer).
// Reset: lexer returns to idle at line 1, offset 0; the token queue empties.
// ----------------------------------------------------------------------------
// toy_language_tokenizer
// Streaming tokenizer: one source byte in, zero to two tokens out per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module toy_language_tokenizer
  import tlt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // in_byte
  input  wire logic        s_axis_tlast,   // end_of_text
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // token_start, token_length, token_line, symbol_code, keyword_id, zero pad
  output logic [47:0]      m_axis_tdata,
  output logic [2:0]       m_axis_tuser,   // token_kind
  output logic             m_axis_tlast    // last_of_run
);

  localparam int QDEPTH = 4;

  lex_state_t st, st_next;
  tok_t       res0, res1;
  logic [1:0] res_count;
  tok_t       queue [QDEPTH];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count, count_next;
  logic       in_xfer, out_xfer;
  tok_t       head;

  // per-byte lexer logic
  tlt_step u_step (
    .st          (st),
    .in_byte     (s_axis_tdata),
    .end_of_text (s_axis_tlast),
    .st_next     (st_next),
    .res0        (res0),
    .res1        (res1),
    .res_count   (res_count)
  );

  // handshakes
  assign s_axis_tready = (count <= 3'd2);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_xfer      = m_axis_tvalid && m_axis_tready;
  assign count_next    = count + 3'(in_xfer ? res_count : 2'd0) - 3'(out_xfer);

  // lexer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= LEX_RESET;
    end else if (in_xfer) begin
      st <= st_next;
    end
  end

  // token queue storage
  always_ff @(posedge clk) begin
    if (in_xfer && (res_count != 2'd0)) begin
      queue[wr_ptr] <= res0;
    end
    if (in_xfer && (res_count == 2'd2)) begin
      queue[wr_ptr + 2'd1] <= res1;
    end
  end

  // token queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_xfer) begin
        wr_ptr <= wr_ptr + res_count;
      end
      if (out_xfer) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count_next;
    end
  end

  // master side
  assign head          = queue[rd_ptr];
  assign m_axis_tvalid = (count != 3'd0);
  assign m_axis_tdata  = {1'b0, head.kw, head.sym, head.line, head.len, head.start};
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;

  // queue never overfills
  assert property (@(posedge clk) disable iff (rst) count <= 3'(QDEPTH))
    else $error("token queue overflow");

  // end of text returns the lexer to its start state
  assert property (@(posedge clk) disable iff (rst)
    (in_xfer && s_axis_tlast) |=> (st.mode == MODE_IDLE && st.boff == '0 && st.lcount == 13'd1))
    else $error("lexer not reset after end of text");

  // a held byte is always one of the two-byte openers
  assert property (@(posedge clk) disable iff (rst)
    (st.mode == MODE_HELD) |-> (st.held == CH_EQ || st.held == CH_BANG || st.held == CH_SLASH))
    else $error("bad held character");

  // line count never leaves its range
  assert property (@(posedge clk) disable iff (rst) st.lcount != '0)
    else $error("line count is zero");

endmodule

`default_nettype wire

// ===== sim/toy_language_tokenizer_tb.sv =====
// ----------------------------------------------------------------------------
// toy_language_tokenizer_tb
// Self-checking bench for the streaming tokenizer. Source bytes go in on the
// slave stream and tokens come back on the master stream, each one compared
// field by field with a behavioral lexer kept in the bench. A short directed
// table covers the edge cases. Random texts of keywords, names, numbers,
// strings, comments, symbols and noise follow. Both sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module toy_language_tokenizer_tb;
  import tlt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] SYM_NONE  = 4'd0;
  localparam logic [3:0] SYM_SEMI  = 4'd0;
  localparam logic [3:0] KW_NONE   = 4'd0;
  localparam logic [3:0] KW_VAR    = 4'd6;
  localparam int         NOT_TYPED = -1;
  localparam int         PAUSE_AT  = 4;     // text before which the sender drains
  localparam int         HOLD_AT   = 80;    // tokens seen before the long sink hold
  localparam int         RAND_BYTES = 1020;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;  // in_byte
  logic        s_axis_tlast = 1'b0;   // end_of_text
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // token_start, token_length, token_line, symbol_code, keyword_id, zero pad
  logic [47:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;          // token_kind
  logic        m_axis_tlast;          // last_of_run

  toy_language_tokenizer u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // behavioral lexer
  // ---------------------------------------------------------------------------
  // entry 2 is filled in at start of stimulus from entry 1 plus its suffix
  string kw_words [9] = '{"set", "call", "", "return", "while", "case",
                          "var", "func", "_cmt"};
  string sym_text = ";(){},+*";

  lex_mode_t     lx_mode;
  logic [7:0]    lx_held;
  logic [TW-1:0] lx_start;
  logic [TW-1:0] lx_len;
  logic [TW-1:0] lx_line;
  logic [TW-1:0] lx_lines;
  logic [TW-1:0] lx_offset;
  logic [8:0]    lx_kwmask;

  tok_t byte_tokens[$];      // tokens caused by the byte just taken
  tok_t pending_tokens[$];   // tokens still owed by the block
  int   errors = 0;
  int   tokens_seen = 0;

  // directed rows may carry a hand-written expectation
  bit   typed_row = 1'b0;
  int   typed_n;
  tok_t typed_tok;

  function automatic logic [TW-1:0] sat13(input logic [TW-1:0] v);
    return (v == TOP13) ? v : v + 13'd1;
  endfunction

  function automatic bit digit_char(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic bit word_char(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || digit_char(c) || (c == CH_UNDER);
  endfunction

  function automatic void add_tok(input logic [2:0] kind, input logic [TW-1:0] st,
                                  input logic [TW-1:0] ln, input logic [TW-1:0] li,
                                  input logic [3:0] sc, input logic [3:0] kc);
    tok_t t;
    t = '{kind: kind, start: st, len: ln, line: li, sym: sc, kw: kc, last: 1'b0};
    byte_tokens.push_back(t);
  endfunction

  // keep only keywords that have byte c at position pos
  function automatic logic [8:0] keep_keywords(input logic [8:0] m,
                                               input logic [TW-1:0] pos,
                                               input logic [7:0] c);
    for (int i = 0; i < 9; i++) begin
      if (pos >= kw_words[i].len() || kw_words[i][pos] != c) m[i] = 1'b0;
    end
    return m;
  endfunction

  // close a name: lowest-numbered keyword of matching length wins
  function automatic void emit_word();
    int hit;
    hit = -1;
    for (int i = 8; i >= 0; i--) begin
      if (lx_kwmask[i] && lx_len == kw_words[i].len()) hit = i;
    end
    if (hit >= 0) add_tok(KIND_KW, lx_start, lx_len, lx_line, SYM_NONE, 4'(hit));
    else add_tok(KIND_IDENT, lx_start, lx_len, lx_line, SYM_NONE, KW_NONE);
  endfunction

  function automatic void open_token(input lex_mode_t m, input logic [TW-1:0] st);
    lx_mode  = m;
    lx_start = st;
    lx_len   = 13'd1;
    lx_line  = lx_lines;
  endfunction

  function automatic void lex_clear();
    lx_mode   = MODE_IDLE;
    lx_held   = 8'h00;
    lx_start  = '0;
    lx_len    = '0;
    lx_line   = 13'd1;
    lx_lines  = 13'd1;
    lx_offset = '0;
    lx_kwmask = '1;
  endfunction

  // byte seen between tokens
  function automatic void first_byte(input logic [7:0] c);
    int code;
    code = -1;
    lx_mode = MODE_IDLE;
    for (int i = 0; i < SYM_SINGLE; i++) begin
      if (sym_text[i] == c) code = i;
    end
    if (c == CH_NL) begin
      lx_lines = sat13(lx_lines);
    end else if (c == CH_SP) begin
      // separator only
    end else if (c == CH_QUOTE) begin
      open_token(MODE_STR, lx_offset + 13'd1);
      lx_len = '0;
    end else if (c == CH_MINUS || digit_char(c)) begin
      open_token(MODE_INT, lx_offset);
    end else if (c == CH_EQ || c == CH_BANG || c == CH_SLASH) begin
      open_token(MODE_HELD, lx_offset);
      lx_held = c;
    end else if (code >= 0) begin
      add_tok(KIND_SYM, lx_offset, 13'd1, lx_lines, 4'(code), KW_NONE);
    end else begin
      open_token(MODE_IDENT, lx_offset);
      lx_kwmask = keep_keywords('1, '0, c);
    end
  endfunction

  function automatic void word_byte(input logic [7:0] c);
    if (word_char(c)) begin
      lx_kwmask = keep_keywords(lx_kwmask, lx_len, c);
      lx_len    = sat13(lx_len);
    end else begin
      emit_word();
      first_byte(c);
    end
  endfunction

  // advance the lexer by one byte, tokens land in byte_tokens
  function automatic void lex_byte(input logic [7:0] c, input logic eot);
    tok_t t;
    byte_tokens.delete();
    case (lx_mode)
      MODE_INT: begin
        if (digit_char(c)) begin
          lx_len = sat13(lx_len);
        end else begin
          add_tok(KIND_INT, lx_start, lx_len, lx_line, SYM_NONE, KW_NONE);
          first_byte(c);
        end
      end
      MODE_IDENT: word_byte(c);
      MODE_STR: begin
        if (c != CH_QUOTE) begin
          lx_len = sat13(lx_len);
        end else if (lx_len == '0) begin
          // empty string: the opening quote becomes a one-byte name
          add_tok(KIND_IDENT, lx_start - 13'd1, 13'd1, lx_line, SYM_NONE, KW_NONE);
          lx_start = lx_offset + 13'd1;
          lx_line  = lx_lines;
        end else begin
          add_tok(KIND_STR, lx_start, lx_len, lx_line, SYM_NONE, KW_NONE);
          lx_mode = MODE_IDLE;
        end
      end
      MODE_CMT: begin
        if (c == CH_NL) begin
          lx_lines = sat13(lx_lines);
          lx_mode  = MODE_IDLE;
        end
      end
      MODE_HELD: begin
        if (lx_held == CH_EQ) begin
          if (c == CH_EQ) begin
            add_tok(KIND_SYM, lx_start, 13'd2, lx_line, SYM_EQEQ, KW_NONE);
            lx_mode = MODE_IDLE;
          end else begin
            add_tok(KIND_SYM, lx_start, 13'd1, lx_line, SYM_ASSIGN, KW_NONE);
            first_byte(c);
          end
        end else if (lx_held == CH_BANG && c == CH_EQ) begin
          add_tok(KIND_SYM, lx_start, 13'd2, lx_line, SYM_NEQ, KW_NONE);
          lx_mode = MODE_IDLE;
        end else if (lx_held == CH_SLASH && c == CH_SLASH) begin
          lx_mode = MODE_CMT;
        end else begin
          // lone '!' or '/' turns into a name that never matches a keyword
          lx_mode   = MODE_IDENT;
          lx_kwmask = '0;
          word_byte(c);
        end
      end
      default: first_byte(c);
    endcase
    lx_offset = lx_offset + 13'd1;

    // end of text flushes whatever is open, then back to the reset state
    if (eot) begin
      case (lx_mode)
        MODE_INT:   add_tok(KIND_INT, lx_start, lx_len, lx_line, SYM_NONE, KW_NONE);
        MODE_IDENT: emit_word();
        MODE_HELD: begin
          if (lx_held == CH_EQ)
            add_tok(KIND_SYM, lx_start, 13'd1, lx_line, SYM_ASSIGN, KW_NONE);
          else
            add_tok(KIND_IDENT, lx_start, 13'd1, lx_line, SYM_NONE, KW_NONE);
        end
        MODE_STR:   add_tok(KIND_ERR, lx_start, lx_len, lx_line, SYM_NONE, KW_NONE);
        default: ;
      endcase
      lex_clear();
    end

    if (byte_tokens.size() > 0) begin
      t = byte_tokens[byte_tokens.size() - 1];
      t.last = 1'b1;
      byte_tokens[byte_tokens.size() - 1] = t;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [7:0] c;
    logic       eot;
    int         n;      // NOT_TYPED, or the hand-written token count
    tok_t       tok;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic void dir_row(input logic [7:0] c, input logic eot, input int n,
                                  input logic [2:0] kind, input logic [TW-1:0] st,
                                  input logic [TW-1:0] ln, input logic [TW-1:0] li,
                                  input logic [3:0] sc, input logic [3:0] kc);
    dir_row_t r;
    r.c   = c;
    r.eot = eot;
    r.n   = n;
    r.tok = '{kind: kind, start: st, len: ln, line: li, sym: sc, kw: kc, last: 1'b1};
    dir_rows.push_back(r);
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] rand_word_char();
    int r;
    r = $urandom_range(0, 37);
    if (r < 26) return 8'("a" + r);
    if (r < 36) return 8'("0" + r - 26);
    return CH_UNDER;
  endfunction

  // one byte transfer on the slave side, then book its tokens
  task automatic send_byte(input logic [7:0] c, input logic eot, input int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= eot;
    do @(posedge clk); while (!s_axis_tready);
    lex_byte(c, eot);
    if (!typed_row) begin
      foreach (byte_tokens[j]) pending_tokens.push_back(byte_tokens[j]);
    end else if (typed_n == 1) begin
      pending_tokens.push_back(typed_tok);
    end
  endtask

  // ---------------------------------------------------------------------------
  // token sink: random stalls, calm stretches and one long hold-off
  // ---------------------------------------------------------------------------
  initial begin : token_sink
    int stall_left;
    int calm_left;
    int r;
    bit held_done;
    stall_left = 0;
    calm_left  = 0;
    held_done  = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        m_axis_tready <= 1'b0;
      end else if (!held_done && tokens_seen >= HOLD_AT) begin
        held_done  = 1'b1;
        stall_left = 400;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        m_axis_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        m_axis_tready <= 1'b1;
        if (r < 20) stall_left = $urandom_range(1, 3);
        else if (r < 23) stall_left = $urandom_range(8, 30);
        else if (r < 28) calm_left = $urandom_range(20, 80);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // token check
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [TW-1:0] want,
                                      input logic [TW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : token_check
    tok_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      tokens_seen++;
      if (pending_tokens.size() == 0) begin
        $error("token with nothing expected: kind %0d start %0d len %0d",
               m_axis_tuser, m_axis_tdata[12:0], m_axis_tdata[25:13]);
        errors++;
      end else begin
        want = pending_tokens.pop_front();
        check_field("token_kind",   TW'(want.kind), TW'(m_axis_tuser));
        check_field("token_start",  want.start,     m_axis_tdata[12:0]);
        check_field("token_length", want.len,       m_axis_tdata[25:13]);
        check_field("token_line",   want.line,      m_axis_tdata[38:26]);
        check_field("symbol_code",  TW'(want.sym),  TW'(m_axis_tdata[42:39]));
        check_field("keyword_id",   TW'(want.kw),   TW'(m_axis_tdata[46:43]));
        check_field("last_of_run",  TW'(want.last), TW'(m_axis_tlast));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [7:0] text_q[$];
    logic [7:0] b;
    int text_no;
    int rand_bytes;
    int pieces;
    int r;
    int k;
    int cnt;
    int drain;
    bit burst;
    bit no_end;

    // the long call keyword is the short one with a suffix
    kw_words[2] = {kw_words[1], "_set"};
    lex_clear();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // edge cases, one text per group, each starting from a clean lexer
    dir_row(";",      1'b1, 1, KIND_SYM,   13'd0, 13'd1, 13'd1, SYM_SEMI, KW_NONE);
    dir_row(8'h00,    1'b1, 1, KIND_IDENT, 13'd0, 13'd1, 13'd1, SYM_NONE, KW_NONE);
    dir_row(8'hFF,    1'b1, 1, KIND_IDENT, 13'd0, 13'd1, 13'd1, SYM_NONE, KW_NONE);
    dir_row(CH_BANG,  1'b0, 0, KIND_STR,   13'd0, 13'd0, 13'd0, SYM_NONE, KW_NONE);
    dir_row(CH_EQ,    1'b1, 1, KIND_SYM,   13'd0, 13'd2, 13'd1, SYM_NEQ,  KW_NONE);
    dir_row(CH_EQ,    1'b0, 0, KIND_STR,   13'd0, 13'd0, 13'd0, SYM_NONE, KW_NONE);
    dir_row(CH_EQ,    1'b1, 1, KIND_SYM,   13'd0, 13'd2, 13'd1, SYM_EQEQ, KW_NONE);
    // lone slash flushes as a one-byte name
    dir_row(CH_SLASH, 1'b1, 1, KIND_IDENT, 13'd0, 13'd1, 13'd1, SYM_NONE, KW_NONE);
    // lone assign followed by a name: two tokens from one byte
    dir_row(CH_EQ,    1'b0, 0, KIND_STR,   13'd0, 13'd0, 13'd0, SYM_NONE, KW_NONE);
    dir_row("a",      1'b1, NOT_TYPED, KIND_STR, 13'd0, 13'd0, 13'd0, SYM_NONE, KW_NONE);
    // comment to end of line, then a lone minus on line 2
    dir_row(CH_SLASH, 1'b0, 0, KIND_STR,   13'd0, 13'd0, 13'd0, SYM_NONE, KW_NONE);
    dir_row(CH_SLASH, 1'b0, 0, KIND_STR,   13'd0, 13'd0, 13'd0, SYM_NONE, KW_NONE);
    dir_row("z",      1'b0, 0, KIND_STR,   13'd0, 13'd0, 13'd0, SYM_NONE, KW_NONE);
    dir_row(CH_NL,    1'b0, 0, KIND_STR,   13'd0, 13'd0, 13'd0, SYM_NONE, KW_NONE);
    dir_row(CH_MINUS, 1'b1, 1, KIND_INT,   13'd4, 13'd1, 13'd2, SYM_NONE, KW_NONE);
    // empty strings back to back, last one left open
    dir_row(CH_QUOTE, 1'b0, 0, KIND_STR,   13'd0, 13'd0, 13'd0, SYM_NONE, KW_NONE);
    dir_row(CH_QUOTE, 1'b0, NOT_TYPED, KIND_STR, 13'd0, 13'd0, 13'd0, SYM_NONE, KW_NONE);
    dir_row(CH_QUOTE, 1'b1, NOT_TYPED, KIND_STR, 13'd0, 13'd0, 13'd0, SYM_NONE, KW_NONE);
    // unterminated string with a newline inside
    dir_row(CH_QUOTE, 1'b0, 0, KIND_STR,   13'd0, 13'd0, 13'd0, SYM_NONE, KW_NONE);
    dir_row("a",      1'b0, 0, KIND_STR,   13'd0, 13'd0, 13'd0, SYM_NONE, KW_NONE);
    dir_row(CH_NL,    1'b1, 1, KIND_ERR,   13'd1, 13'd2, 13'd1, SYM_NONE, KW_NONE);
    // keyword
    dir_row("v",      1'b0, 0, KIND_STR,   13'd0, 13'd0, 13'd0, SYM_NONE, KW_NONE);
    dir_row("a",      1'b0, 0, KIND_STR,   13'd0, 13'd0, 13'd0, SYM_NONE, KW_NONE);
    dir_row("r",      1'b1, 1, KIND_KW,    13'd0, 13'd3, 13'd1, SYM_NONE, KW_VAR);

    foreach (dir_rows[i]) begin
      typed_row = (dir_rows[i].n != NOT_TYPED);
      typed_n   = dir_rows[i].n;
      typed_tok = dir_rows[i].tok;
      send_byte(dir_rows[i].c, dir_rows[i].eot, pick_gap());
    end
    typed_row = 1'b0;

    // random texts built from well-formed pieces plus some noise
    text_no    = 0;
    rand_bytes = 0;
    while (rand_bytes < RAND_BYTES) begin
      if (text_no == PAUSE_AT) begin
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending_tokens.size() != 0);
      end

      text_q.delete();
      pieces = $urandom_range(1, 10);
      repeat (pieces) begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          // keyword, sometimes cut short or run on
          k = $urandom_range(0, 8);
          for (int j = 0; j < kw_words[k].len(); j++) text_q.push_back(kw_words[k][j]);
          r = $urandom_range(0, 99);
          if (r < 15) void'(text_q.pop_back());
          else if (r < 30) text_q.push_back(rand_word_char());
        end else if (r < 30) begin
          // name with an ordinary or odd first byte
          r = $urandom_range(0, 99);
          if (r < 70) text_q.push_back(8'("a" + $urandom_range(0, 25)));
          else if (r < 80) text_q.push_back(CH_UNDER);
          else if (r < 92) text_q.push_back(8'("A" + $urandom_range(0, 25)));
          else text_q.push_back(8'h09);
          repeat ($urandom_range(0, 6)) text_q.push_back(rand_word_char());
        end else if (r < 42) begin
          // number, with or without a leading minus
          if ($urandom_range(0, 3) == 0) begin
            text_q.push_back(CH_MINUS);
            cnt = $urandom_range(0, 4);
          end else begin
            cnt = $urandom_range(1, 4);
          end
          repeat (cnt) text_q.push_back(8'("0" + $urandom_range(0, 9)));
        end else if (r < 55) begin
          // symbol, single or double
          k = $urandom_range(0, 10);
          if (k < SYM_SINGLE) begin
            text_q.push_back(sym_text[k]);
          end else if (k == 8) begin
            text_q.push_back(CH_EQ);
          end else begin
            text_q.push_back((k == 9) ? CH_EQ : CH_BANG);
            text_q.push_back(CH_EQ);
          end
        end else if (r < 65) begin
          // string with arbitrary content, now and then left open
          text_q.push_back(CH_QUOTE);
          repeat ($urandom_range(0, 6)) begin
            b = 8'($urandom_range(0, 255));
            text_q.push_back((b == CH_QUOTE) ? 8'("q") : b);
          end
          if ($urandom_range(0, 9) != 0) text_q.push_back(CH_QUOTE);
        end else if (r < 71) begin
          // comment to end of line
          text_q.push_back(CH_SLASH);
          text_q.push_back(CH_SLASH);
          repeat ($urandom_range(0, 5)) begin
            b = 8'($urandom_range(0, 255));
            text_q.push_back((b == CH_NL) ? 8'("c") : b);
          end
          text_q.push_back(CH_NL);
        end else if (r < 80) begin
          // a held first byte on its own
          k = $urandom_range(0, 2);
          text_q.push_back((k == 0) ? CH_BANG : (k == 1) ? CH_SLASH : CH_EQ);
        end else begin
          text_q.push_back(8'($urandom_range(0, 255)));
        end

        // separator
        r = $urandom_range(0, 99);
        if (r >= 25 && r < 65) text_q.push_back(CH_SP);
        else if (r >= 65 && r < 85) text_q.push_back(CH_NL);
        else if (r >= 85) repeat ($urandom_range(2, 3)) text_q.push_back(CH_SP);
      end

      // now and then a text runs on into the next one
      no_end = ($urandom_range(0, 9) == 0);
      burst  = ($urandom_range(0, 3) == 0);
      foreach (text_q[j]) begin
        send_byte(text_q[j], (j == text_q.size() - 1) && !no_end, burst ? 0 : pick_gap());
      end
      rand_bytes += text_q.size();
      text_no++;
    end

    // close off any text left running
    send_byte(CH_SP, 1'b1, pick_gap());
    s_axis_tvalid <= 1'b0;

    // drain and settle
    drain = 0;
    while (pending_tokens.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);
    if (pending_tokens.size() != 0) begin
      $error("%0d tokens never arrived", pending_tokens.size());
      errors++;
    end
    if (errors == 0) begin
      $display("toy_language_tokenizer_tb: PASS");
    end else begin
      $display("toy_language_tokenizer_tb: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #(50_000_000);
    $display("toy_language_tokenizer_tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
